@@ design/vmt_pkg.sv @@
package vmt_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int NUM_REGS = 8;
   localparam int FIFO_DEPTH = 2;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_WZERO = 2'd1;
   localparam logic [1:0] STATUS_SAT = 2'd2;

   typedef logic [NUM_REGS-1:0][63:0] coef_regs_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } vertex_in_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [1:0]         status;
   } vertex_out_type;

   // classified row sums handed from front to back
   typedef struct packed {
      logic signed [2:0][31:0] t;
      logic signed [31:0]      w;
      logic                    sat;
      logic                    w_zero;
      logic                    w_one;
   } front_entry_type;

endpackage

@@ design/vmt_front.sv @@
module vmt_front #(
   parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  vmt_pkg::vertex_in_type   in_data,
   input  vmt_pkg::coef_regs_type   coefs,
   output logic                     out_valid,
   output vmt_pkg::front_entry_type out_entry
);

   localparam int SW = 66;

   function automatic logic signed [31:0] coef(input vmt_pkg::coef_regs_type r, input int k);
      coef = $signed(r[k/2][(k%2)*32 +: 32]);
   endfunction

   function automatic logic [32:0] sat32(input logic signed [SW:0] v);
      logic signed [SW:0] hi;
      logic signed [SW:0] lo;
      hi = (SW+1)'(33'sh0_7FFF_FFFF);
      lo = -(SW+1)'(33'sh0_8000_0000);
      if (v > hi) sat32 = {1'b1, 32'h7FFF_FFFF};
      else if (v < lo) sat32 = {1'b1, 32'h8000_0000};
      else sat32 = {1'b0, v[31:0]};
   endfunction

   logic signed [31:0] vin [3];
   logic signed [63:0] prod_ff [12];
   logic signed [63:0] prod_in [12];
   logic signed [SW-1:0] sum_ff [4];
   logic signed [SW-1:0] sum_in [4];
   logic [2:0] valid_ff;
   vmt_pkg::front_entry_type entry_ff;
   vmt_pkg::front_entry_type entry_in;

   assign vin[0] = in_data.pos_x;
   assign vin[1] = in_data.pos_y;
   assign vin[2] = in_data.pos_z;

   always_comb begin
      logic signed [SW:0] full;
      logic [32:0] s;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r*3+c] = vin[c] * coef(coefs, r*4+c);
         end
      end
      for (int r = 0; r < 4; r++) begin
         sum_in[r] = (SW'(prod_ff[r*3]) + SW'(prod_ff[r*3+1]) + SW'(prod_ff[r*3+2]))
                     >>> FRAC_BITS;
      end
      entry_in = '0;
      for (int r = 0; r < 4; r++) begin
         full = (SW+1)'(sum_ff[r]) + (SW+1)'(coef(coefs, r*4+3));
         s = sat32(full);
         if (r < 3) entry_in.t[r] = s[31:0];
         else entry_in.w = s[31:0];
         entry_in.sat = entry_in.sat | s[32];
      end
      entry_in.w_zero = (entry_in.w == 32'sd0);
      entry_in.w_one = (entry_in.w == (32'sd1 <<< FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff <= sum_in;
      entry_ff <= entry_in;
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[2];
   assign out_entry = entry_ff;

endmodule

@@ design/vmt_fifo.sv @@
module vmt_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  vmt_pkg::front_entry_type push_data,
   output logic                     pop,
   output vmt_pkg::front_entry_type pop_data,
   output logic                     full
);

   localparam int PW = $clog2(vmt_pkg::FIFO_DEPTH);

   vmt_pkg::front_entry_type mem_ff [vmt_pkg::FIFO_DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   cnt_ff, cnt_in;
   logic do_push;

   // back end never stalls, so it drains every cycle there is an entry
   assign pop = (cnt_ff != '0);
   assign full = (cnt_ff == (PW+1)'(vmt_pkg::FIFO_DEPTH));
   assign do_push = push && !full;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = do_push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in = pop ? PW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(do_push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ design/vmt_back.sv @@
module vmt_back #(
   parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  vmt_pkg::front_entry_type in_entry,
   output logic                     out_valid,
   output vmt_pkg::vertex_out_type  out_data
);

   localparam int DW = 32 + FRAC_BITS;
   localparam logic [DW-1:0] LIM = DW'(64'h8000_0000);

   logic [DW-1:0] dvd_ff [DW+1][3];
   logic [DW-1:0] quo_ff [DW+1][3];
   logic [31:0]   rem_ff [DW+1][3];
   logic          neg_ff [DW+1][3];
   logic [31:0]   dv_ff  [DW+1];
   vmt_pkg::front_entry_type ent_ff [DW+1];
   logic [DW:0]   val_ff;
   logic          oval_ff;
   vmt_pkg::vertex_out_type odata_ff, odata_in;

   function automatic logic [31:0] mag(input logic signed [31:0] v);
      mag = v[31] ? 32'(-v) : 32'(v);
   endfunction

   // one quotient bit per stage, one restoring step per lane
   always_ff @(posedge clock) begin
      logic [32:0] trial;
      dv_ff[0] <= mag(in_entry.w);
      ent_ff[0] <= in_entry;
      for (int l = 0; l < 3; l++) begin
         dvd_ff[0][l] <= DW'(mag(in_entry.t[l])) << FRAC_BITS;
         quo_ff[0][l] <= '0;
         rem_ff[0][l] <= '0;
         neg_ff[0][l] <= in_entry.t[l][31] ^ in_entry.w[31];
      end
      for (int k = 1; k <= DW; k++) begin
         dv_ff[k] <= dv_ff[k-1];
         ent_ff[k] <= ent_ff[k-1];
         for (int l = 0; l < 3; l++) begin
            trial = {rem_ff[k-1][l], dvd_ff[k-1][l][DW-1]};
            neg_ff[k][l] <= neg_ff[k-1][l];
            dvd_ff[k][l] <= dvd_ff[k-1][l] << 1;
            if (trial >= {1'b0, dv_ff[k-1]}) begin
               rem_ff[k][l] <= 32'(trial - {1'b0, dv_ff[k-1]});
               quo_ff[k][l] <= {quo_ff[k-1][l][DW-2:0], 1'b1};
            end else begin
               rem_ff[k][l] <= trial[31:0];
               quo_ff[k][l] <= {quo_ff[k-1][l][DW-2:0], 1'b0};
            end
         end
      end
      odata_ff <= odata_in;
      if (reset) begin
         val_ff <= '0;
         oval_ff <= 1'b0;
      end else begin
         val_ff <= {val_ff[DW-1:0], in_valid};
         oval_ff <= val_ff[DW];
      end
   end

   always_comb begin
      logic [31:0] q [3];
      logic        qsat;
      logic [DW-1:0] m;
      vmt_pkg::front_entry_type e;
      e = ent_ff[DW];
      qsat = 1'b0;
      for (int l = 0; l < 3; l++) begin
         m = quo_ff[DW][l];
         if (neg_ff[DW][l]) begin
            if (m > LIM) begin
               q[l] = 32'h8000_0000;
               qsat = 1'b1;
            end else begin
               q[l] = 32'(-m);
            end
         end else if (m >= LIM) begin
            q[l] = 32'h7FFF_FFFF;
            qsat = 1'b1;
         end else begin
            q[l] = m[31:0];
         end
      end
      if (e.w_zero || e.w_one) begin
         odata_in.out_x = e.t[0];
         odata_in.out_y = e.t[1];
         odata_in.out_z = e.t[2];
      end else begin
         odata_in.out_x = q[0];
         odata_in.out_y = q[1];
         odata_in.out_z = q[2];
      end
      if (e.w_zero) odata_in.status = vmt_pkg::STATUS_WZERO;
      else if (e.sat || (qsat && !e.w_one)) odata_in.status = vmt_pkg::STATUS_SAT;
      else odata_in.status = vmt_pkg::STATUS_OK;
   end

   assign out_valid = oval_ff;
   assign out_data = odata_ff;

endmodule

@@ design/vertex_matrix_transform.sv @@
// Throughput: one vertex per cycle, set by the bit-per-stage pipelined divider.
// The receiver cannot stall; each result is shown for one cycle only.
// Reset (synchronous, active high) loads the identity matrix and empties
// all pipeline stages and the queue.
module vertex_matrix_transform #(
   parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // input channel
   input  logic                    start,
   output logic                    busy,
   input  vmt_pkg::vertex_in_type  req_data,
   // result channel
   output logic                    rsp_valid,
   output vmt_pkg::vertex_out_type rsp_data,
   // configuration port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [5:0]              paddr,
   input  logic [63:0]             pwdata,
   output logic [63:0]             prdata,
   output logic                    pready
);

   // matrix registers, two Q coefficients per register, low column in bits 31:0
   vmt_pkg::coef_regs_type cfg_ff;
   logic cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = cfg_ff[paddr[5:3]];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[0] <= 64'(1) << FRAC_BITS;
         cfg_ff[1] <= '0;
         cfg_ff[2] <= 64'(1) << (FRAC_BITS + 32);
         cfg_ff[3] <= '0;
         cfg_ff[4] <= '0;
         cfg_ff[5] <= 64'(1) << FRAC_BITS;
         cfg_ff[6] <= '0;
         cfg_ff[7] <= 64'(1) << (FRAC_BITS + 32);
      end else if (cfg_wr) begin
         cfg_ff[paddr[5:3]] <= pwdata;
      end
   end

   // front: products, row sums, saturation and w classification
   logic accept;
   logic front_valid;
   vmt_pkg::front_entry_type front_entry;

   assign accept = start && !busy;

   vmt_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_data),
      .coefs     (cfg_ff),
      .out_valid (front_valid),
      .out_entry (front_entry)
   );

   // short queue decouples front from the divider back end
   logic q_pop;
   logic q_full;
   vmt_pkg::front_entry_type q_data;

   vmt_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_entry),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full)
   );

   // busy only rises if the queue fills; the back end drains one per cycle
   assign busy = q_full;

   // back: perspective divide and result select
   vmt_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_pop),
      .in_entry  (q_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

@@ design/vmt_checker.sv @@
module vmt_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    busy,
   input logic                    rsp_valid,
   input vmt_pkg::vertex_out_type rsp_data,
   input logic                    pready
);

   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised although back end drains every cycle");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status != 2'd3))
      else $error("undefined status code");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

endmodule

bind vertex_matrix_transform vmt_checker u_vmt_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

@@ sim/vertex_transform_checker.sv @@
module vertex_transform_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  vmt_pkg::vertex_in_type  req_data,
   input  logic                    rsp_valid,
   input  vmt_pkg::vertex_out_type rsp_data,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [5:0]              paddr,
   input  logic [63:0]             pwdata,
   input  logic                    pready,
   output int                      pending,
   output int                      fail_count,
   output int                      result_count
);

   localparam int FB = vmt_pkg::FRAC_BITS_DEF;
   localparam longint ONE = longint'(1) << FB;

   logic [63:0]             matrix [vmt_pkg::NUM_REGS];
   vmt_pkg::vertex_out_type expected_vertices [$];

   function automatic logic signed [31:0] coef(int k);
      logic [63:0] r;
      r = matrix[k >> 1];
      return (k & 1) ? r[63:32] : r[31:0];
   endfunction

   function automatic longint clamp32(logic signed [127:0] v, inout bit sat);
      if (v > 128'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (v < -128'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return longint'(v);
   endfunction

   // exact floor of the product sum, then translation, then clamp
   function automatic longint row_sum(int row, vmt_pkg::vertex_in_type v, inout bit sat);
      longint              p0, p1, p2;
      logic signed [127:0] acc;
      p0  = longint'(v.pos_x) * longint'(coef(row*4));
      p1  = longint'(v.pos_y) * longint'(coef(row*4 + 1));
      p2  = longint'(v.pos_z) * longint'(coef(row*4 + 2));
      acc = p0;
      acc = acc + p1 + p2;
      acc = (acc >>> FB) + coef(row*4 + 3);
      return clamp32(acc, sat);
   endfunction

   function automatic vmt_pkg::vertex_out_type transform_vertex(vmt_pkg::vertex_in_type v);
      vmt_pkg::vertex_out_type r;
      longint                  t [3];
      longint                  w;
      bit                      sat;
      sat = 0;
      for (int i = 0; i < 3; i++) t[i] = row_sum(i, v, sat);
      w = row_sum(3, v, sat);
      if (w == 0) begin
         r.status = vmt_pkg::STATUS_WZERO;
      end else begin
         if (w != ONE) begin
            for (int i = 0; i < 3; i++) t[i] = clamp32((t[i] * ONE) / w, sat);
         end
         r.status = sat ? vmt_pkg::STATUS_SAT : vmt_pkg::STATUS_OK;
      end
      r.out_x = t[0][31:0];
      r.out_y = t[1][31:0];
      r.out_z = t[2][31:0];
      return r;
   endfunction

   assign pending = expected_vertices.size();

   always @(posedge clock) begin
      vmt_pkg::vertex_out_type e;
      if (reset) begin
         matrix[0] <= 64'(ONE);
         matrix[1] <= '0;
         matrix[2] <= 64'(ONE) << 32;
         matrix[3] <= '0;
         matrix[4] <= '0;
         matrix[5] <= 64'(ONE);
         matrix[6] <= '0;
         matrix[7] <= 64'(ONE) << 32;
         expected_vertices.delete();
         fail_count   <= 0;
         result_count <= 0;
      end else begin
         if (psel && penable && pwrite && pready && (paddr >> 3) < vmt_pkg::NUM_REGS)
            matrix[paddr >> 3] <= pwdata;
         if (start && !busy)
            expected_vertices.push_back(transform_vertex(req_data));
         if (rsp_valid) begin
            result_count <= result_count + 1;
            if (expected_vertices.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_vertices.pop_front();
               if (e.out_x !== rsp_data.out_x || e.out_y !== rsp_data.out_y ||
                   e.out_z !== rsp_data.out_z || e.status !== rsp_data.status) begin
                  $display("%0t: mismatch expected x=%h y=%h z=%h st=%0d",
                           $time, e.out_x, e.out_y, e.out_z, e.status);
                  $display("%0t:          actual   x=%h y=%h z=%h st=%0d",
                           $time, rsp_data.out_x, rsp_data.out_y, rsp_data.out_z,
                           rsp_data.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

@@ sim/tb_vertex_matrix_transform.sv @@
module tb_vertex_matrix_transform;

   // pipeline depth from start transfer to result strobe, plus margin
   localparam int DRAIN_CYCLES = 5 + 32 + vmt_pkg::FRAC_BITS_DEF + 10;
   localparam logic [31:0] FX_ONE = 32'h0001_0000;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   vmt_pkg::vertex_in_type  req_data;
   logic                    rsp_valid;
   vmt_pkg::vertex_out_type rsp_data;
   logic                    psel, penable, pwrite, pready;
   logic [5:0]              paddr;
   logic [63:0]             pwdata, prdata;

   int pending, fail_count, result_count;
   int sent_count;
   bit idle_enable;

   vertex_matrix_transform DUT (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   vertex_transform_checker checker_inst (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .pending(pending), .fail_count(fail_count), .result_count(result_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the pipeline hangs
   initial begin
      #3000000;
      $display("vertex_matrix_transform regression: fail");
      $finish;
   end

   // setup cycle, then access cycle; the register takes the write at the
   // edge that ends the access cycle
   task automatic csr_write(int idx, logic [63:0] value);
      @(posedge clock);
      psel    <= 1;
      penable <= 0;
      pwrite  <= 1;
      paddr   <= 6'(idx * 8);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
   endtask

   // lets every outstanding result drain before touching the matrix
   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_matrix(logic [63:0] m [8]);
      wait_drained();
      for (int i = 0; i < 8; i++) csr_write(i, m[i]);
   endtask

   // one vertex transfer; start stays high across back-to-back transfers
   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      if (idle_enable) begin
         while ($urandom_range(99) < 17) begin
            start <= 0;
            @(posedge clock);
         end
      end
      start          <= 1;
      req_data.pos_x <= x;
      req_data.pos_y <= y;
      req_data.pos_z <= z;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
         2: return 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
         default: return $urandom_range(3) == 0 ? 32'h8000_0000 :
                         $urandom_range(1) ? 32'h7FFF_FFFF : 32'h0;
      endcase
   endfunction

   // coefficient between -2.0 and 2.0 most of the time, raw bits otherwise
   function automatic logic [31:0] rand_coef();
      if ($urandom_range(4) == 0) return $urandom;
      return 32'($signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) send_vertex(rand_coord(), rand_coord(), rand_coord());
      start <= 0;
   endtask

   initial begin
      logic [63:0] m [8];
      logic [31:0] edge_vals [6];
      int          timeout;

      reset    <= 1;
      start    <= 0;
      req_data <= '0;
      psel     <= 0;
      penable  <= 0;
      pwrite   <= 0;
      paddr    <= '0;
      pwdata   <= '0;
      idle_enable = 1;
      sent_count  = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset identity, w equal to one, no divide
      edge_vals = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, FX_ONE, 32'hFFFF_0000, 32'h1};
      for (int i = 0; i < 6; i++)
         send_vertex(edge_vals[i], edge_vals[(i+2)%6], edge_vals[(i+4)%6]);

      // directed: w row all zero, so w is zero and status flags it
      m = '{64'(FX_ONE), 64'h0, 64'(FX_ONE) << 32, 64'h0,
            64'h0, 64'(FX_ONE), 64'h0, 64'h0};
      start <= 0;
      load_matrix(m);
      for (int i = 0; i < 4; i++)
         send_vertex(edge_vals[i], edge_vals[i+1], edge_vals[i+2]);

      // directed: all coefficients at the extremes, sums saturate
      start <= 0;
      m = '{default: 64'h7FFF_FFFF_7FFF_FFFF};
      load_matrix(m);
      for (int i = 0; i < 3; i++)
         send_vertex(edge_vals[i+1], edge_vals[i+2], edge_vals[i+3]);
      start <= 0;
      m = '{default: 64'h8000_0000_8000_0000};
      load_matrix(m);
      for (int i = 0; i < 3; i++)
         send_vertex(edge_vals[i], edge_vals[i+1], edge_vals[i+3]);

      // directed: perspective matrix, w = z, quotients and tiny w
      start <= 0;
      m = '{64'(FX_ONE), 64'h0, 64'(FX_ONE) << 32, 64'h0,
            64'h0, 64'(FX_ONE), 64'h0, 64'h0};
      m[7] = 64'(FX_ONE);
      load_matrix(m);
      send_vertex(32'h0020_0000, 32'hFFE0_0000, 32'h0000_0001);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
      send_vertex(32'h0003_0000, 32'h0005_0000, 32'h0002_0000);
      send_vertex(32'h0003_0000, 32'h0005_0000, 32'hFFFE_0000);
      start <= 0;

      // random: fresh matrices, small-range vertices mixed with raw bits
      for (int ph = 0; ph < 7; ph++) begin
         for (int i = 0; i < 8; i++) m[i] = {rand_coef(), rand_coef()};
         if (ph == 1) begin                              // affine, w from m15 only
            m[6] = 64'h0;
            m[7] = {m[7][63:32], 32'h0};
         end
         if (ph == 2) m = '{default: 64'hFFFF_FFFF_FFFF_FFFF};
         if (ph == 3) m = '{default: 64'h0};
         load_matrix(m);
         idle_enable = (ph != 4);                        // back-to-back stretch
         random_phase(30);
         // hold off until the pipeline is empty, then resume mid-phase
         while (pending != 0) @(posedge clock);
         random_phase(30);
      end
      idle_enable = 1;

      // a few raw-bit matrices at random
      for (int ph = 0; ph < 2; ph++) begin
         for (int i = 0; i < 8; i++) m[i] = {$urandom, $urandom};
         load_matrix(m);
         random_phase(15);
      end

      start <= 0;
      timeout = 0;
      while (pending != 0 && timeout < 100000) begin
         @(posedge clock);
         timeout++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d vertices over 14 matrix settings, %0d results checked",
               sent_count, result_count);
      $display("covered identity, w zero, saturation, perspective divide and raw bits");
      if (fail_count == 0 && pending == 0)
         $display("vertex_matrix_transform regression: pass");
      else
         $display("vertex_matrix_transform regression: fail");
      $finish;
   end

endmodule

@@ vertex_matrix_transform.f @@
design/vmt_pkg.sv
design/vmt_front.sv
design/vmt_fifo.sv
design/vmt_back.sv
design/vertex_matrix_transform.sv
design/vmt_checker.sv
sim/vertex_transform_checker.sv
sim/tb_vertex_matrix_transform.sv
